### src/sfe_pkg.sv
// Shared types, symbols and helper functions of the serial frame encoder.
`timescale 1ns / 1ps

package sfe_pkg;

  // Link symbols.
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] ESC_BIT = 8'h80;
  localparam logic [7:0] HDR_MARK = 8'h04;

  // Largest payload a frame may announce; longer lengths saturate.
  localparam logic [4:0] MAX_PAYLOAD = 5'd31;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic       is_start;
    logic [7:0] hdr_hi;
    logic [7:0] hdr_lo;
    logic       has_data;
    logic [7:0] data;
    logic       do_close;
    logic [7:0] check;
  } cmd_t;

  // Output sequencer phases.
  typedef enum logic [7:0] {
    PH_STX      = 8'b0000_0001,
    PH_HDR1     = 8'b0000_0010,
    PH_HDR2     = 8'b0000_0100,
    PH_DATA     = 8'b0000_1000,
    PH_DATA_ESC = 8'b0001_0000,
    PH_CHK      = 8'b0010_0000,
    PH_CHK_ESC  = 8'b0100_0000,
    PH_ETX      = 8'b1000_0000
  } phase_t;

  // Folds the running 13-bit sum into one byte with end-around carry.
  function automatic logic [7:0] fold_sum(input logic [12:0] s);
    logic [8:0] t;
    logic [8:0] u;
    t = {1'b0, s[7:0]} + {4'b0, s[12:8]};
    u = {1'b0, t[7:0]} + {8'b0, t[8]};
    return u[7:0];
  endfunction

  // True for bytes that must be sent as an escape pair.
  function automatic logic needs_esc(input logic [7:0] b);
    return (b == SYM_STX) || (b == SYM_ETX) || (b == SYM_DLE);
  endfunction

endpackage

### src/sfe_front.sv
// Front part: accepts requests, tracks the open frame and classifies work.
`timescale 1ns / 1ps

module sfe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             q_full,
  input  logic             start_frame,
  input  logic [4:0]       module_id,
  input  logic [4:0]       payload_len,
  input  logic [7:0]       data_byte,
  output logic             push,
  output sfe_pkg::cmd_t    cmd
);

  logic        frame_open;
  logic [4:0]  bytes_left;
  logic [12:0] check_sum;

  logic        accept;
  logic [4:0]  len_sat;
  logic [12:0] sum_base;
  logic [12:0] sum_new;
  logic [4:0]  left_base;
  logic [4:0]  left_new;
  logic        has_data;
  logic        close;

  assign accept = in_valid && !q_full;

  // Classify the request against the current frame state.
  always_comb begin
    len_sat = (payload_len > sfe_pkg::MAX_PAYLOAD) ? sfe_pkg::MAX_PAYLOAD : payload_len;
    if (start_frame) begin
      sum_base  = {8'b0, module_id};
      left_base = len_sat;
    end else begin
      sum_base  = check_sum;
      left_base = bytes_left;
    end
    has_data = (left_base != 5'd0);
    sum_new  = has_data ? (sum_base + {5'b0, data_byte}) : sum_base;
    left_new = has_data ? (left_base - 5'd1) : left_base;
    close    = !has_data || (left_new == 5'd0);
  end

  // Build the request for the back part.
  always_comb begin
    push         = accept && (start_frame || frame_open);
    cmd.is_start = start_frame;
    cmd.hdr_hi   = {6'b0, module_id[4:3]} | sfe_pkg::HDR_MARK;
    cmd.hdr_lo   = {module_id[2:0], len_sat};
    cmd.has_data = has_data;
    cmd.data     = data_byte;
    cmd.do_close = close;
    cmd.check    = sfe_pkg::fold_sum(sum_new);
  end

  // Frame state; payload without an open frame leaves it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 5'd0;
      check_sum  <= 13'd0;
    end else if (push) begin
      frame_open <= !close;
      bytes_left <= close ? 5'd0 : left_new;
      check_sum  <= sum_new;
    end
  end

endmodule

### src/sfe_queue.sv
// Small request queue between the front and back parts.
`timescale 1ns / 1ps

module sfe_queue #(
  parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfe_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output sfe_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfe_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/sfe_back.sv
// Back part: expands each request into link bytes through an output register.
`timescale 1ns / 1ps

module sfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  sfe_pkg::cmd_t q_head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          frame_done
);

  sfe_pkg::cmd_t   cur;
  sfe_pkg::phase_t phase;
  sfe_pkg::phase_t phase_next;
  sfe_pkg::phase_t first_phase;
  logic            cur_valid;

  logic            load_ok;
  logic            fire;
  logic [7:0]      byte_val;
  logic            last;
  logic            done;

  assign load_ok = !out_valid || !out_stall;
  assign fire    = cur_valid && load_ok;
  assign pop     = !q_empty && (!cur_valid || (fire && last));

  // Entry phase of the request at the queue head.
  always_comb begin
    if (q_head.is_start) begin
      first_phase = sfe_pkg::PH_STX;
    end else if (q_head.has_data) begin
      first_phase = sfe_pkg::PH_DATA;
    end else begin
      first_phase = sfe_pkg::PH_CHK;
    end
  end

  // Byte of the current phase and the phase that follows it.
  always_comb begin
    byte_val   = sfe_pkg::SYM_ETX;
    last       = 1'b0;
    done       = 1'b0;
    phase_next = phase;
    case (phase)
      sfe_pkg::PH_STX: begin
        byte_val   = sfe_pkg::SYM_STX;
        phase_next = sfe_pkg::PH_HDR1;
      end
      sfe_pkg::PH_HDR1: begin
        byte_val   = cur.hdr_hi;
        phase_next = sfe_pkg::PH_HDR2;
      end
      sfe_pkg::PH_HDR2: begin
        byte_val = cur.hdr_lo;
        if (cur.has_data) begin
          phase_next = sfe_pkg::PH_DATA;
        end else if (cur.do_close) begin
          phase_next = sfe_pkg::PH_CHK;
        end else begin
          last = 1'b1;
        end
      end
      sfe_pkg::PH_DATA: begin
        if (sfe_pkg::needs_esc(cur.data)) begin
          byte_val   = sfe_pkg::SYM_DLE;
          phase_next = sfe_pkg::PH_DATA_ESC;
        end else begin
          byte_val = cur.data;
          if (cur.do_close) begin
            phase_next = sfe_pkg::PH_CHK;
          end else begin
            last = 1'b1;
          end
        end
      end
      sfe_pkg::PH_DATA_ESC: begin
        byte_val = cur.data | sfe_pkg::ESC_BIT;
        if (cur.do_close) begin
          phase_next = sfe_pkg::PH_CHK;
        end else begin
          last = 1'b1;
        end
      end
      sfe_pkg::PH_CHK: begin
        if (sfe_pkg::needs_esc(cur.check)) begin
          byte_val   = sfe_pkg::SYM_DLE;
          phase_next = sfe_pkg::PH_CHK_ESC;
        end else begin
          byte_val   = cur.check;
          phase_next = sfe_pkg::PH_ETX;
        end
      end
      sfe_pkg::PH_CHK_ESC: begin
        byte_val   = cur.check | sfe_pkg::ESC_BIT;
        phase_next = sfe_pkg::PH_ETX;
      end
      sfe_pkg::PH_ETX: begin
        byte_val = sfe_pkg::SYM_ETX;
        last     = 1'b1;
        done     = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // Current request and its phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= sfe_pkg::PH_STX;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= first_phase;
    end else if (fire && last) begin
      cur_valid <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte   <= byte_val;
      run_last   <= last;
      frame_done <= done;
    end
  end

endmodule

### src/serial_frame_encoder_dle_bcc.sv
// Serial telegram framer with byte stuffing and folded sum check.
//
// Input channel (in_valid / in_stall): a request with start_frame set opens
// a frame for module_id with payload_len bytes and carries the first payload
// byte in data_byte; later requests carry one payload byte each. Requests
// without an open frame produce nothing. Output channel (out_valid /
// out_stall): the link bytes of each request on out_byte, with run_last on the
// last byte caused by an input request and frame_done on the closing ETX.
// The front part updates the frame state and classifies each request in the
// cycle it is accepted; requests wait in a small queue (QUEUE_DEPTH deep)
// for the back part, which sends one byte per cycle while the receiver does
// not stall, through an output register. When idle, an accepted request
// passes the queue entry and the current-request and output registers before
// its first byte appears. A request yields one to eight bytes, one per output
// sequencer phase; the single output byte per cycle sets the rate. While the
// receiver stalls, the output register holds and input requests are taken
// until the queue is full. Reset clears the frame state, queue and out_valid.
`timescale 1ns / 1ps

module serial_frame_encoder_dle_bcc #(
  parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       start_frame,
  input  logic [4:0] module_id,
  input  logic [4:0] payload_len,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_done
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  sfe_pkg::cmd_t q_in;
  sfe_pkg::cmd_t q_head;

  assign in_stall = q_full;

  sfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .q_full      (q_full),
    .start_frame (start_frame),
    .module_id   (module_id),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .push        (q_push),
    .cmd         (q_in)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  sfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

  // The closing ETX always ends the run of its request.
  a_etx_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame end without run end");

  // Bytes of one request leave back to back once the receiver takes them.
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a request's byte run");

  // The queue cannot be full and empty at once.
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue count out of range");

  // Nothing is popped from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
